@@ sv/stbs_pkg.sv @@
`default_nettype none
package stbs_pkg;

	localparam int DATA_W = 32;
	localparam int IDX_W  = 10;
	localparam int CNT_W  = 11;
	localparam int POS_W  = 10;

	// kind field codes
	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

	typedef enum logic {
		OP_WRITE,
		OP_SEARCH
	} op_t;

	// one queued command: table write or key search
	typedef struct packed {
		op_t                       op;
		logic [IDX_W-1:0]          addr;
		logic signed [DATA_W-1:0]  data;
	} cmd_t;

	// one result beat
	typedef struct packed {
		logic             done;
		logic             found;
		logic [POS_W-1:0] position;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CMP
	} state_t;

endpackage
`default_nettype wire

@@ sv/sorted_table_binary_search_unit.sv @@
`default_nettype none
// Sorted-table exact-match binary search.
// Command channel: an item is taken when start is high and busy is low.
//   kind 0 writes entry_value at entry_index (indexes past the table are
//   dropped); kind 1 searches for search_key. Writes give no result.
// Config channel: cfg_data sets entry_count on a cfg_valid/cfg_ready beat;
//   cfg_ready is always high. Counts above TABLE_DEPTH saturate.
// Result: done strobes for one cycle with found and position (0 if absent).
//   The receiver cannot stall; each result is shown exactly once.
// Flow: a two-entry queue decouples the front from the search sequencer.
//   Each search probe is a registered read of the table memory and then a
//   compare, with at most floor(log2(entry_count))+1 probes. The sequencer
//   first takes the beat off the queue; on a miss a final empty-range check
//   follows the probes; the result strobe is registered. The sequencer
//   takes the next beat while the strobe is up, so searches run one at a
//   time while the queue holds further beats. A write is done as its beat
//   is taken off the queue. busy rises only when the queue fills.
// Reset: arst_n clears the queue, the sequencer and entry_count to 0; table
//   contents are undefined until written.
module sorted_table_binary_search_unit #(
	parameter int TABLE_DEPTH = 1024
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output      logic                               busy,
	input  wire logic                               kind,
	input  wire logic [stbs_pkg::IDX_W-1:0]         entry_index,
	input  wire logic signed [stbs_pkg::DATA_W-1:0] entry_value,
	input  wire logic signed [stbs_pkg::DATA_W-1:0] search_key,
	input  wire logic                               cfg_valid,
	output      logic                               cfg_ready,
	input  wire logic [stbs_pkg::CNT_W-1:0]         cfg_data,
	output      logic                               done,
	output      logic                               found,
	output      logic [stbs_pkg::POS_W-1:0]         position
);
	import stbs_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH+1);

	logic [CNT_W-1:0] entry_count_q;
	logic [CW-1:0]    count_sat;
	logic             cmd_valid;
	logic             cmd_pop;
	cmd_t             cmd;
	res_t             res;

	// entry_count register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			entry_count_q <= '0;
		else if (cfg_valid && cfg_ready)
			entry_count_q <= cfg_data;
	end

	// clamp count to the table
	always_comb begin
		if (32'(entry_count_q) > TABLE_DEPTH)
			count_sat = CW'(TABLE_DEPTH);
		else
			count_sat = CW'(entry_count_q);
	end

	stbs_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.search_key  (search_key),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop)
	);

	stbs_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.count     (count_sat),
		.res       (res)
	);

	assign done     = res.done;
	assign found    = res.found;
	assign position = res.position;

`ifndef SYNTHESIS
	// results never arrive back to back
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// a miss reports position zero
	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> (position == '0))
		else $error("miss with nonzero position");

	// the queue fills only through an accepted beat
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without an accepted beat");
`endif

endmodule
`default_nettype wire

@@ sv/stbs_front.sv @@
`default_nettype none
module stbs_front #(
	parameter int TABLE_DEPTH = 1024
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output      logic                              busy,
	input  wire logic                              kind,
	input  wire logic [stbs_pkg::IDX_W-1:0]        entry_index,
	input  wire logic signed [stbs_pkg::DATA_W-1:0] entry_value,
	input  wire logic signed [stbs_pkg::DATA_W-1:0] search_key,
	output      logic                              cmd_valid,
	output      stbs_pkg::cmd_t                    cmd,
	input  wire logic                              cmd_pop
);
	import stbs_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       accept;
	logic       push;
	logic       pop;
	cmd_t       new_cmd;
	logic       keep;

	// classify: searches always go on, writes past the table are dropped
	always_comb begin
		new_cmd = '0;
		keep    = 1'b0;
		if (kind == KIND_SEARCH) begin
			new_cmd.op   = OP_SEARCH;
			new_cmd.data = search_key;
			keep         = 1'b1;
		end else begin
			new_cmd.op   = OP_WRITE;
			new_cmd.addr = entry_index;
			new_cmd.data = entry_value;
			keep         = (32'(entry_index) < TABLE_DEPTH);
		end
	end

	assign busy      = (fill_q == 2'd2);
	assign accept    = start && !busy;
	assign push      = accept && keep;
	assign cmd_valid = (fill_q != 2'd0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = slot_q[rd_ptr_q];

	// two-entry queue storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= new_cmd;
	end

	// queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				fill_q <= fill_q + 2'd1;
			else if (pop && !push)
				fill_q <= fill_q - 2'd1;
		end
	end

endmodule
`default_nettype wire

@@ sv/stbs_back.sv @@
`default_nettype none
module stbs_back #(
	parameter int TABLE_DEPTH = 1024
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cmd_valid,
	input  wire stbs_pkg::cmd_t                         cmd,
	output      logic                                   cmd_pop,
	input  wire logic [$clog2(TABLE_DEPTH+1)-1:0]       count,
	output      stbs_pkg::res_t                         res
);
	import stbs_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH+1);

	logic signed [DATA_W-1:0] mem [TABLE_DEPTH];
	logic signed [DATA_W-1:0] rdata_q;
	logic signed [DATA_W-1:0] key_q;
	logic [CW-1:0]            low_q;
	logic [CW-1:0]            hiex_q;
	logic [AW-1:0]            mid_q;
	state_t                   state_q;
	state_t                   state_d;
	logic [CW:0]              sum;
	logic [AW-1:0]            mid;
	logic                     we;
	logic                     re;
	logic                     done_q;
	logic                     found_q;
	logic [POS_W-1:0]         position_q;

	// midpoint of the half-open range [low, hiex)
	assign sum = {1'b0, low_q} + {1'b0, hiex_q} - {{CW{1'b0}}, 1'b1};
	assign mid = AW'(sum >> 1);

	// next state
	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		we      = 1'b0;
		re      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					if (cmd.op == OP_WRITE)
						we = 1'b1;
					else
						state_d = ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (low_q < hiex_q) begin
					re      = 1'b1;
					state_d = ST_CMP;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_CMP: begin
				if (rdata_q == key_q)
					state_d = ST_IDLE;
				else
					state_d = ST_PROBE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// table memory, one write or one registered read a cycle
	always_ff @(posedge clk) begin
		if (we)
			mem[AW'(cmd.addr)] <= cmd.data;
		if (re)
			rdata_q <= mem[mid];
	end

	// search datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid && cmd.op == OP_SEARCH) begin
			key_q  <= cmd.data;
			low_q  <= '0;
			hiex_q <= count;
		end
		if (re)
			mid_q <= mid;
		if (state_q == ST_CMP && rdata_q != key_q) begin
			if (rdata_q < key_q)
				low_q <= CW'(mid_q) + CW'(1);
			else
				hiex_q <= CW'(mid_q);
		end
		if (state_q == ST_PROBE && !(low_q < hiex_q)) begin
			found_q    <= 1'b0;
			position_q <= '0;
		end else if (state_q == ST_CMP && rdata_q == key_q) begin
			found_q    <= 1'b1;
			position_q <= POS_W'(mid_q);
		end
	end

	// control state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_PROBE && !(low_q < hiex_q))
				|| (state_q == ST_CMP && rdata_q == key_q);
		end
	end

	assign res.done     = done_q;
	assign res.found    = found_q;
	assign res.position = position_q;

endmodule
`default_nettype wire
